/* rtl/vfst_pkg.sv */
// Shared constants and widths for the video frame size and region tracker.
package vfst_pkg;

   // Field widths
   localparam int SCALE_W   = 12;
   localparam int HPOS_W    = 10;
   localparam int VPOS_W    = 9;
   localparam int LINE_W    = 12;
   localparam int WIDTH_W   = 16;
   localparam int HEIGHT_W  = 12;
   localparam int ADDR_W    = 24;
   localparam int MEMSZ_W   = 25;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 25;

   // Horizontal end recomputed as line_width * 1024 / xs
   localparam int FRAC_W     = 10;
   localparam int DIV_W      = LINE_W + FRAC_W;
   localparam int DIV_STEP_W = $clog2(DIV_W);

   // Shared multiplier operands and product
   localparam int MUL_A_W = DIV_W;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int HEIGHT_SHIFT = 26;

   localparam logic [MUL_B_W-1:0]  HEIGHT_NUM = 17'd66366;
   localparam logic [WIDTH_W-1:0]  DEF_WIDTH  = 16'd320;
   localparam logic [HEIGHT_W-1:0] DEF_HEIGHT = 12'd240;
   localparam logic [MEMSZ_W-1:0]  DEF_MEMSZ  = 25'd8388608;

   localparam int MAX_REGIONS_DEF = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FORCE_SIZE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FORCED_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FORCED_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TRACK_REGIONS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MEMORY_SIZE   = 3'd4;

endpackage

/* rtl/vfst_div.sv */
// Restoring divider, one quotient bit per cycle.
module vfst_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [vfst_pkg::DIV_W-1:0]   dividend,
   input  logic [vfst_pkg::SCALE_W-1:0] divisor,
   output logic                         done,
   output logic [vfst_pkg::DIV_W-1:0]   quotient
);

   localparam int DW = vfst_pkg::DIV_W;
   localparam int SW = vfst_pkg::SCALE_W;
   localparam int CW = vfst_pkg::DIV_STEP_W;

   logic [DW-1:0] quo_ff;
   logic [SW-1:0] rem_ff;
   logic [SW-1:0] dvs_ff;
   logic [CW-1:0] step_ff;
   logic          run_ff;
   logic          done_ff;

   logic [SW:0]   rem_sh;
   logic          fits;
   logic [SW:0]   rem_in;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DW-1]};
      fits   = rem_sh >= {1'b0, dvs_ff};
      rem_in = fits ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == CW'(DW - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         // remainder stays below the divisor, so the top bit drops
         quo_ff <= {quo_ff[DW-2:0], fits};
         rem_ff <= rem_in[SW-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/vfst_mul.sv */
// Shared unsigned multiplier with a registered product.
module vfst_mul (
   input  logic                         clock,
   input  logic [vfst_pkg::MUL_A_W-1:0] op_a,
   input  logic [vfst_pkg::MUL_B_W-1:0] op_b,
   output logic [vfst_pkg::MUL_P_W-1:0] product
);

   logic [vfst_pkg::MUL_P_W-1:0] prod_ff;
   logic [vfst_pkg::MUL_P_W-1:0] prod_in;

   assign prod_in = vfst_pkg::MUL_P_W'(op_a) * vfst_pkg::MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

/* rtl/vfst_regions.sv */
// Display region table: begin/finish memory and valid count.
module vfst_regions #(
   parameter int MAX_REGIONS = vfst_pkg::MAX_REGIONS_DEF,
   parameter int IDX_W       = $clog2(MAX_REGIONS),
   parameter int CNT_W       = $clog2(MAX_REGIONS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [IDX_W-1:0]             rd_idx,
   input  logic                         insert,
   input  logic [vfst_pkg::ADDR_W-1:0]  ins_begin,
   input  logic [vfst_pkg::MEMSZ_W-1:0] ins_finish,
   output logic [vfst_pkg::ADDR_W-1:0]  rd_begin,
   output logic [vfst_pkg::MEMSZ_W-1:0] rd_finish,
   output logic [CNT_W-1:0]             count
);

   localparam int AW = vfst_pkg::ADDR_W;
   localparam int EW = vfst_pkg::MEMSZ_W;

   logic [AW+EW-1:0] mem [MAX_REGIONS];
   logic [AW+EW-1:0] rd_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             not_full;
   logic [IDX_W-1:0] slot;

   always_comb begin
      not_full = count_ff < CNT_W'(MAX_REGIONS);
      // full table: overwrite slot 0
      slot     = not_full ? count_ff[IDX_W-1:0] : '0;
      count_in = (insert && not_full) ? count_ff + 1'b1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         mem[slot] <= {ins_begin, ins_finish};
      end
      rd_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rd_begin  = rd_ff[AW+EW-1:EW];
   assign rd_finish = rd_ff[EW-1:0];
   assign count     = count_ff;

endmodule

/* rtl/video_frame_size_and_region_tracker.sv */
// Top level: sequencer for frame size derivation and region tracking.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the result strobe. The result sits on the rsp_ ports for the single
// cycle of rsp_strobe and cannot be held off. Accepted items pass S_DEF when
// size is forced, else S_MW, S_MH1, S_MH2, S_HGT and S_DEF, after S_DIV (the
// shared 22-step divider) when the horizontal end is recomputed; tracking on
// adds S_AREA, S_END, a walk over stored regions (up to MAX_REGIONS) and S_INS
// when a region is inserted, before S_DONE.
// All multiplies go through one shared multiplier, one product per cycle.
// Configuration writes are taken at any time but must be made while idle.
module video_frame_size_and_region_tracker #(
   parameter int MAX_REGIONS = vfst_pkg::MAX_REGIONS_DEF,
   parameter int CNT_W       = $clog2(MAX_REGIONS + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [31:0]                    req_x_scale_word,
   input  logic [31:0]                    req_y_scale_word,
   input  logic [31:0]                    req_h_start_word,
   input  logic [31:0]                    req_v_start_word,
   input  logic [vfst_pkg::LINE_W-1:0]    req_line_width,
   input  logic [31:0]                    req_origin_addr,
   output logic                           rsp_strobe,
   output logic [vfst_pkg::WIDTH_W-1:0]   rsp_frame_width,
   output logic [vfst_pkg::HEIGHT_W-1:0]  rsp_frame_height,
   output logic                           rsp_region_added,
   output logic [CNT_W-1:0]               rsp_region_count,
   input  logic                           csr_wr_en,
   input  logic [vfst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vfst_pkg::CSR_DAT_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_REGIONS);
   localparam int SW    = vfst_pkg::SCALE_W;
   localparam int HW    = vfst_pkg::HPOS_W;
   localparam int VW    = vfst_pkg::VPOS_W;
   localparam int DW    = vfst_pkg::DIV_W;
   localparam int WW    = vfst_pkg::WIDTH_W;
   localparam int HTW   = vfst_pkg::HEIGHT_W;
   localparam int AW    = vfst_pkg::ADDR_W;
   localparam int EW    = vfst_pkg::MEMSZ_W;
   localparam int MAW   = vfst_pkg::MUL_A_W;
   localparam int MBW   = vfst_pkg::MUL_B_W;
   localparam int MPW   = vfst_pkg::MUL_P_W;
   localparam int SUM_W = EW + 6;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DIV  = 4'd1;
   localparam logic [3:0] S_MW   = 4'd2;
   localparam logic [3:0] S_MH1  = 4'd3;
   localparam logic [3:0] S_MH2  = 4'd4;
   localparam logic [3:0] S_HGT  = 4'd5;
   localparam logic [3:0] S_DEF  = 4'd6;
   localparam logic [3:0] S_AREA = 4'd7;
   localparam logic [3:0] S_END  = 4'd8;
   localparam logic [3:0] S_SRCH = 4'd9;
   localparam logic [3:0] S_INS  = 4'd10;
   localparam logic [3:0] S_DONE = 4'd11;

   // Configuration registers
   logic           force_size_ff;
   logic [WW-1:0]  forced_width_ff;
   logic [HTW-1:0] forced_height_ff;
   logic           track_ff;
   logic [EW-1:0]  mem_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         force_size_ff    <= 1'b0;
         forced_width_ff  <= vfst_pkg::DEF_WIDTH;
         forced_height_ff <= vfst_pkg::DEF_HEIGHT;
         track_ff         <= 1'b0;
         mem_size_ff      <= vfst_pkg::DEF_MEMSZ;
      end else if (csr_wr_en) begin
         case (csr_index)
            vfst_pkg::REG_FORCE_SIZE:    force_size_ff    <= csr_wdata[0];
            vfst_pkg::REG_FORCED_WIDTH:  forced_width_ff  <= csr_wdata[WW-1:0];
            vfst_pkg::REG_FORCED_HEIGHT: forced_height_ff <= csr_wdata[HTW-1:0];
            vfst_pkg::REG_TRACK_REGIONS: track_ff         <= csr_wdata[0];
            vfst_pkg::REG_MEMORY_SIZE:   mem_size_ff      <= csr_wdata[EW-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer and working registers
   logic [3:0]       state_ff, state_in;
   logic [SW-1:0]    xs_ff, xs_in;
   logic [SW-1:0]    ys_ff, ys_in;
   logic [DW-1:0]    hend_ff, hend_in;
   logic [HW-1:0]    hstart_ff, hstart_in;
   logic [VW-1:0]    vend_ff, vend_in;
   logic [VW-1:0]    vstart_ff, vstart_in;
   logic [AW-1:0]    origin_ff, origin_in;
   logic [WW-1:0]    width_ff, width_in;
   logic [HTW-1:0]   height_ff, height_in;
   logic [EW-1:0]    end_ff, end_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             added_ff, added_in;

   logic             accept;
   logic [HW-1:0]    in_hend;
   logic [HW-1:0]    in_hstart;
   logic [SW-1:0]    in_xs;
   logic             div_go;
   logic             div_done;
   logic [DW-1:0]    div_quo;
   logic [MAW-1:0]   mul_a;
   logic [MBW-1:0]   mul_b;
   logic [MPW-1:0]   prod;
   logic [DW-1:0]    span_h;
   logic [VW-1:0]    span_v;
   logic [SUM_W-1:0] end_sum;
   logic [IDX_W-1:0] rd_idx;
   logic             insert;
   logic [AW-1:0]    rd_begin;
   logic [EW-1:0]    rd_finish;
   logic [CNT_W-1:0] count;
   logic             hit;
   logic             last;

   assign accept    = start && (state_ff == S_IDLE);
   assign in_hend   = req_h_start_word[HW-1:0];
   assign in_hstart = req_h_start_word[16 +: HW];
   assign in_xs     = req_x_scale_word[SW-1:0];
   assign div_go    = accept && !force_size_ff && (in_hend == in_hstart) && (in_xs != '0);

   vfst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend ({req_line_width, {vfst_pkg::FRAC_W{1'b0}}}),
      .divisor  (in_xs),
      .done     (div_done),
      .quotient (div_quo)
   );

   vfst_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   vfst_regions #(
      .MAX_REGIONS (MAX_REGIONS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_regions (
      .clock      (clock),
      .reset      (reset),
      .rd_idx     (rd_idx),
      .insert     (insert),
      .ins_begin  (origin_ff),
      .ins_finish (end_ff),
      .rd_begin   (rd_begin),
      .rd_finish  (rd_finish),
      .count      (count)
   );

   always_comb begin
      span_h = (hend_ff > DW'(hstart_ff)) ? (hend_ff - DW'(hstart_ff)) : '0;
      span_v = (vend_ff > vstart_ff) ? (vend_ff - vstart_ff) : '0;

      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MW: begin
            mul_a = span_h;
            mul_b = MBW'(xs_ff);
         end
         S_MH1: begin
            mul_a = MAW'(ys_ff);
            mul_b = MBW'(span_v);
         end
         S_MH2: begin
            mul_a = prod[MAW-1:0];
            mul_b = vfst_pkg::HEIGHT_NUM;
         end
         S_AREA: begin
            mul_a = MAW'(width_ff);
            mul_b = MBW'(height_ff);
         end
         default: ;
      endcase

      // region end = origin + width * height * 4, clamped to memory size
      end_sum = SUM_W'(origin_ff) + {prod[SUM_W-3:0], 2'b00};

      hit = (({1'b0, rd_begin} <= end_ff) && (rd_begin >= origin_ff)) ||
            (({1'b0, origin_ff} <= rd_finish) && (origin_ff >= rd_begin));
      last = (CNT_W'(idx_ff) + 1'b1) == count;

      // walk reads one entry ahead of the compare
      rd_idx = (state_ff == S_SRCH) ? idx_ff + 1'b1 : '0;
      insert = (state_ff == S_INS);
   end

   always_comb begin
      state_in  = state_ff;
      xs_in     = xs_ff;
      ys_in     = ys_ff;
      hend_in   = hend_ff;
      hstart_in = hstart_ff;
      vend_in   = vend_ff;
      vstart_in = vstart_ff;
      origin_in = origin_ff;
      width_in  = width_ff;
      height_in = height_ff;
      end_in    = end_ff;
      idx_in    = idx_ff;
      added_in  = added_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               xs_in     = in_xs;
               ys_in     = req_y_scale_word[SW-1:0];
               hend_in   = DW'(in_hend);
               hstart_in = in_hstart;
               vend_in   = req_v_start_word[1 +: VW];
               vstart_in = req_v_start_word[17 +: VW];
               origin_in = req_origin_addr[AW-1:0];
               width_in  = forced_width_ff;
               height_in = forced_height_ff;
               added_in  = 1'b0;
               if (force_size_ff) begin
                  state_in = S_DEF;
               end else if (div_go) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_MW;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               hend_in  = div_quo;
               state_in = S_MW;
            end
         end
         S_MW: begin
            state_in = S_MH1;
         end
         S_MH1: begin
            width_in = (prod[MPW-1:vfst_pkg::FRAC_W] > (MPW - vfst_pkg::FRAC_W)'({WW{1'b1}}))
                       ? {WW{1'b1}} : prod[vfst_pkg::FRAC_W +: WW];
            state_in = S_MH2;
         end
         S_MH2: begin
            state_in = S_HGT;
         end
         S_HGT: begin
            height_in = (prod[MPW-1:vfst_pkg::HEIGHT_SHIFT] >
                         (MPW - vfst_pkg::HEIGHT_SHIFT)'({HTW{1'b1}}))
                        ? {HTW{1'b1}} : prod[vfst_pkg::HEIGHT_SHIFT +: HTW];
            state_in  = S_DEF;
         end
         S_DEF: begin
            if (width_ff == '0) width_in = vfst_pkg::DEF_WIDTH;
            if (height_ff == '0) height_in = vfst_pkg::DEF_HEIGHT;
            state_in = track_ff ? S_AREA : S_DONE;
         end
         S_AREA: begin
            state_in = S_END;
         end
         S_END: begin
            end_in   = (end_sum > SUM_W'(mem_size_ff)) ? mem_size_ff : end_sum[EW-1:0];
            idx_in   = '0;
            state_in = (count == '0) ? S_INS : S_SRCH;
         end
         S_SRCH: begin
            if (hit) begin
               state_in = S_DONE;
            end else if (last) begin
               state_in = S_INS;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_INS: begin
            added_in = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         added_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         added_ff <= added_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff     <= xs_in;
      ys_ff     <= ys_in;
      hend_ff   <= hend_in;
      hstart_ff <= hstart_in;
      vend_ff   <= vend_in;
      vstart_ff <= vstart_in;
      origin_ff <= origin_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      end_ff    <= end_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = (state_ff == S_DONE);
   assign rsp_frame_width  = width_ff;
   assign rsp_frame_height = height_ff;
   assign rsp_region_added = added_ff;
   assign rsp_region_count = count;

endmodule

/* dv/tb_video_frame_size_and_region_tracker.sv */
// Self-checking testbench for the video frame size and region tracker.
`timescale 1ns / 100ps

module tb_video_frame_size_and_region_tracker;

   localparam int N_REGIONS      = vfst_pkg::MAX_REGIONS_DEF;
   localparam int COUNT_W        = $clog2(N_REGIONS + 1);
   localparam int CSR_SLOTS      = 2 ** vfst_pkg::CSR_IDX_W;
   localparam int RANDOM_ITEMS   = 259;
   localparam int N_PHASES       = 4;
   localparam int QUIET_LIMIT    = 2000;
   localparam int TAIL_CYCLES    = 64;

   typedef struct {
      logic [31:0]                 x_scale_word;
      logic [31:0]                 y_scale_word;
      logic [31:0]                 h_start_word;
      logic [31:0]                 v_start_word;
      logic [vfst_pkg::LINE_W-1:0] line_width;
      logic [31:0]                 origin_addr;
   } frame_update_type;

   typedef struct {
      logic [vfst_pkg::WIDTH_W-1:0]  frame_width;
      logic [vfst_pkg::HEIGHT_W-1:0] frame_height;
      logic                          region_added;
      logic [COUNT_W-1:0]            region_count;
   } frame_result_type;

   typedef struct {
      bit                          force_size;
      bit [vfst_pkg::WIDTH_W-1:0]  forced_width;
      bit [vfst_pkg::HEIGHT_W-1:0] forced_height;
      bit                          track_regions;
      bit [vfst_pkg::MEMSZ_W-1:0]  memory_size;
   } tracker_setup_type;

   class frame_size_scoreboard;
      bit                          force_size    = 1'b0;
      bit [vfst_pkg::WIDTH_W-1:0]  forced_width  = vfst_pkg::DEF_WIDTH;
      bit [vfst_pkg::HEIGHT_W-1:0] forced_height = vfst_pkg::DEF_HEIGHT;
      bit                          track_regions = 1'b0;
      bit [vfst_pkg::MEMSZ_W-1:0]  memory_size   = vfst_pkg::DEF_MEMSZ;

      bit [vfst_pkg::ADDR_W-1:0]   region_begin [N_REGIONS];
      bit [vfst_pkg::MEMSZ_W-1:0]  region_finish [N_REGIONS];
      int                          valid_regions = 0;

      frame_result_type            expected_sizes [$];

      int n_updates    = 0;
      int n_checked    = 0;
      int n_recomputed = 0;
      int n_forced     = 0;
      int n_inserted   = 0;
      int n_overwrites = 0;
      int n_overlaps   = 0;
      int n_errors     = 0;

      function void set_reg(int idx, logic [vfst_pkg::CSR_DAT_W-1:0] data);
         case (idx)
            vfst_pkg::REG_FORCE_SIZE:    force_size    = data[0];
            vfst_pkg::REG_FORCED_WIDTH:  forced_width  = data[vfst_pkg::WIDTH_W-1:0];
            vfst_pkg::REG_FORCED_HEIGHT: forced_height = data[vfst_pkg::HEIGHT_W-1:0];
            vfst_pkg::REG_TRACK_REGIONS: track_regions = data[0];
            vfst_pkg::REG_MEMORY_SIZE:   memory_size   = data[vfst_pkg::MEMSZ_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_sizes.size();
      endfunction

      function void note_update(frame_update_type u);
         bit [vfst_pkg::SCALE_W-1:0] xs, ys;
         bit [31:0]                  hend, hstart, vend, vstart;
         bit [63:0]                  w, h, hspan, vspan, reg_start, reg_end;
         bit                         hit;
         int                         slot;
         frame_result_type           r;

         n_updates++;
         r.region_added = 1'b0;
         if (!force_size) begin
            xs     = u.x_scale_word[vfst_pkg::SCALE_W-1:0];
            ys     = u.y_scale_word[vfst_pkg::SCALE_W-1:0];
            hend   = 32'(u.h_start_word[9:0]);
            hstart = 32'(u.h_start_word[25:16]);
            vend   = 32'(u.v_start_word[9:1]);
            vstart = 32'(u.v_start_word[25:17]);
            // Equal start and end with nonzero x scale: take the end from the line width instead
            if (hend == hstart && xs != 0) begin
               hend = 32'((64'(u.line_width) * 1024) / 64'(xs));
               n_recomputed++;
            end
            hspan = hend > hstart ? 64'(hend - hstart) : 64'd0;
            vspan = vend > vstart ? 64'(vend - vstart) : 64'd0;
            w = (64'(xs) * hspan) >> vfst_pkg::FRAC_W;
            if (w > 64'hFFFF) w = 64'hFFFF;
            h = (64'(ys) * 64'(vfst_pkg::HEIGHT_NUM) * vspan) >> vfst_pkg::HEIGHT_SHIFT;
            if (h > 64'hFFF) h = 64'hFFF;
         end else begin
            w = 64'(forced_width);
            h = 64'(forced_height);
            n_forced++;
         end
         if (w == 0) w = 64'(vfst_pkg::DEF_WIDTH);
         if (h == 0) h = 64'(vfst_pkg::DEF_HEIGHT);

         if (track_regions) begin
            reg_start = 64'(u.origin_addr[vfst_pkg::ADDR_W-1:0]);
            reg_end   = reg_start + w * h * 64'd4;
            if (reg_end > 64'(memory_size)) reg_end = 64'(memory_size);
            hit = 1'b0;
            // Stop at the first stored region that overlaps
            for (int i = 0; i < valid_regions; i++) begin
               if (!hit) begin
                  if (region_begin[i] <= reg_end && region_begin[i] >= reg_start)
                     hit = 1'b1;
                  else if (reg_start <= region_finish[i] && reg_start >= region_begin[i])
                     hit = 1'b1;
               end
            end
            if (hit) begin
               n_overlaps++;
            end else begin
               slot = valid_regions < N_REGIONS ? valid_regions : 0;
               if (valid_regions == N_REGIONS) n_overwrites++;
               region_begin[slot]  = reg_start[vfst_pkg::ADDR_W-1:0];
               region_finish[slot] = reg_end[vfst_pkg::MEMSZ_W-1:0];
               if (valid_regions < N_REGIONS) valid_regions++;
               r.region_added = 1'b1;
               n_inserted++;
            end
         end

         r.frame_width  = w[vfst_pkg::WIDTH_W-1:0];
         r.frame_height = h[vfst_pkg::HEIGHT_W-1:0];
         r.region_count = valid_regions[COUNT_W-1:0];
         expected_sizes.push_back(r);
      endfunction

      function void check_result(logic [vfst_pkg::WIDTH_W-1:0] fw,
                                 logic [vfst_pkg::HEIGHT_W-1:0] fh,
                                 logic added, logic [COUNT_W-1:0] cnt);
         frame_result_type want;

         if (expected_sizes.size() == 0) begin
            n_errors++;
            $error("result with no update pending: width %0d height %0d", fw, fh);
            return;
         end
         want = expected_sizes.pop_front();
         n_checked++;
         if (fw !== want.frame_width) begin
            n_errors++;
            $error("frame_width: expected %0d, actual %0d", want.frame_width, fw);
         end
         if (fh !== want.frame_height) begin
            n_errors++;
            $error("frame_height: expected %0d, actual %0d", want.frame_height, fh);
         end
         if (added !== want.region_added) begin
            n_errors++;
            $error("region_added: expected %0d, actual %0d", want.region_added, added);
         end
         if (cnt !== want.region_count) begin
            n_errors++;
            $error("region_count: expected %0d, actual %0d", want.region_count, cnt);
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [31:0]                     req_x_scale_word = '0;
   logic [31:0]                     req_y_scale_word = '0;
   logic [31:0]                     req_h_start_word = '0;
   logic [31:0]                     req_v_start_word = '0;
   logic [vfst_pkg::LINE_W-1:0]     req_line_width   = '0;
   logic [31:0]                     req_origin_addr  = '0;
   logic                            rsp_strobe;
   logic [vfst_pkg::WIDTH_W-1:0]    rsp_frame_width;
   logic [vfst_pkg::HEIGHT_W-1:0]   rsp_frame_height;
   logic                            rsp_region_added;
   logic [COUNT_W-1:0]              rsp_region_count;
   logic                            csr_wr_en = 1'b0;
   logic [vfst_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [vfst_pkg::CSR_DAT_W-1:0]  csr_wdata = '0;

   frame_size_scoreboard sb = new();
   int quiet_cycles = 0;

   video_frame_size_and_region_tracker #(
      .MAX_REGIONS (N_REGIONS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_x_scale_word (req_x_scale_word),
      .req_y_scale_word (req_y_scale_word),
      .req_h_start_word (req_h_start_word),
      .req_v_start_word (req_v_start_word),
      .req_line_width   (req_line_width),
      .req_origin_addr  (req_origin_addr),
      .rsp_strobe       (rsp_strobe),
      .rsp_frame_width  (rsp_frame_width),
      .rsp_frame_height (rsp_frame_height),
      .rsp_region_added (rsp_region_added),
      .rsp_region_count (rsp_region_count),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin : watch_ports
      frame_update_type seen;
      if (!reset) begin
         // Check the finishing item before noting the one taken at this edge
         if (rsp_strobe === 1'b1)
            sb.check_result(rsp_frame_width, rsp_frame_height, rsp_region_added,
                            rsp_region_count);
         if (start && busy === 1'b0) begin
            seen.x_scale_word = req_x_scale_word;
            seen.y_scale_word = req_y_scale_word;
            seen.h_start_word = req_h_start_word;
            seen.v_start_word = req_v_start_word;
            seen.line_width   = req_line_width;
            seen.origin_addr  = req_origin_addr;
            sb.note_update(seen);
         end
         if (rsp_strobe === 1'b1 || (start && busy === 1'b0)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
               $display("simulation failed");
               $finish;
            end
         end
      end
   end

   function automatic logic [31:0] hword(int hs, int he);
      return {6'd0, 10'(hs), 6'd0, 10'(he)};
   endfunction

   function automatic logic [31:0] vword(int vs, int ve);
      return {6'd0, 9'(vs), 7'd0, 9'(ve), 1'b0};
   endfunction

   function automatic frame_update_type make_update(logic [31:0] xw, logic [31:0] yw,
                                                    logic [31:0] hw, logic [31:0] vw,
                                                    int lw, logic [31:0] origin);
      frame_update_type u;
      u.x_scale_word = xw;
      u.y_scale_word = yw;
      u.h_start_word = hw;
      u.v_start_word = vw;
      u.line_width   = vfst_pkg::LINE_W'(lw);
      u.origin_addr  = origin;
      return u;
   endfunction

   function automatic frame_update_type random_update();
      frame_update_type u;
      int               hs, vs;

      u.x_scale_word = $urandom();
      u.y_scale_word = $urandom();
      u.h_start_word = $urandom();
      u.v_start_word = $urandom();
      u.line_width   = vfst_pkg::LINE_W'($urandom());
      u.origin_addr  = $urandom();
      // Mostly plausible video timings, so frames stay small enough to fit
      if ($urandom_range(99) < 60) begin
         u.x_scale_word[vfst_pkg::SCALE_W-1:0] = vfst_pkg::SCALE_W'($urandom_range(256, 2048));
         u.y_scale_word[vfst_pkg::SCALE_W-1:0] = vfst_pkg::SCALE_W'($urandom_range(256, 2048));
         hs = $urandom_range(0, 200);
         vs = $urandom_range(0, 50);
         u.h_start_word[25:16] = 10'(hs);
         u.h_start_word[9:0]   = 10'(hs + $urandom_range(0, 823));
         u.v_start_word[25:17] = 9'(vs);
         u.v_start_word[9:1]   = 9'(vs + $urandom_range(0, 461));
      end
      if ($urandom_range(3) == 0) u.h_start_word[9:0] = u.h_start_word[25:16];
      if ($urandom_range(19) == 0) u.x_scale_word[vfst_pkg::SCALE_W-1:0] = '0;
      // Cluster origins on a coarse grid so that regions collide
      if ($urandom_range(1) == 0)
         u.origin_addr[19:0] = 20'($urandom_range(0, 3)) << 18;
      return u;
   endfunction

   task automatic wait_drained();
      // Let the last accepted item show up as busy and pending first
      @(posedge clock);
      while (sb.pending() != 0 || busy !== 1'b0) @(posedge clock);
   endtask

   task automatic apply_setup(tracker_setup_type s);
      logic [vfst_pkg::CSR_DAT_W-1:0] data;

      start <= 1'b0;
      wait_drained();
      // Write every index back to back; spare indexes get noise
      for (int i = 0; i < CSR_SLOTS; i++) begin
         case (i)
            vfst_pkg::REG_FORCE_SIZE:    data = vfst_pkg::CSR_DAT_W'(s.force_size);
            vfst_pkg::REG_FORCED_WIDTH:  data = vfst_pkg::CSR_DAT_W'(s.forced_width);
            vfst_pkg::REG_FORCED_HEIGHT: data = vfst_pkg::CSR_DAT_W'(s.forced_height);
            vfst_pkg::REG_TRACK_REGIONS: data = vfst_pkg::CSR_DAT_W'(s.track_regions);
            vfst_pkg::REG_MEMORY_SIZE:   data = vfst_pkg::CSR_DAT_W'(s.memory_size);
            default:                     data = vfst_pkg::CSR_DAT_W'($urandom());
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= vfst_pkg::CSR_IDX_W'(i);
         csr_wdata <= data;
         @(posedge clock);
         sb.set_reg(i, data);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_update(frame_update_type u, int gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_x_scale_word <= u.x_scale_word;
      req_y_scale_word <= u.y_scale_word;
      req_h_start_word <= u.h_start_word;
      req_v_start_word <= u.v_start_word;
      req_line_width   <= u.line_width;
      req_origin_addr  <= u.origin_addr;
      start            <= 1'b1;
      // Hold until an edge sees start with busy low
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic run_directed();
      tracker_setup_type s;

      s = '{1'b0, vfst_pkg::DEF_WIDTH, vfst_pkg::DEF_HEIGHT, 1'b0, vfst_pkg::DEF_MEMSZ};
      apply_setup(s);
      send_update(make_update('0, '0, '0, '0, 0, '0), 0);
      send_update(make_update('1, '1, '1, '1, 4095, '1), 0);
      // Zero x scale, both with and without equal horizontal start and end
      send_update(make_update(32'h0, 32'h400, hword(100, 500), vword(10, 250), 640, '0), 0);
      send_update(make_update(32'h0, 32'h400, hword(64, 64), vword(10, 250), 640, '0), 0);
      send_update(make_update(32'h0FFF_0200, 32'h0FFF_0400, hword(40, 40), vword(20, 500),
                              640, '0), 0);
      // Reversed spans clamp to zero
      send_update(make_update(32'h400, 32'h400, hword(700, 100), vword(400, 10), 0, '0), 0);
      send_update(make_update(32'hFFF, 32'hFFF, hword(0, 1023), vword(0, 511), 0, '0), 0);
      send_update(make_update(32'h001, 32'h001, hword(0, 1023), vword(0, 511), 4095, '0), 0);
      send_update(make_update(32'hFFF, 32'h001, hword(1023, 1023), vword(511, 511), 1, '0), 0);

      // Forced zero size falls back to the defaults; exercise overlap both ways
      s = '{1'b1, '0, '0, 1'b1, vfst_pkg::MEMSZ_W'(16777216)};
      apply_setup(s);
      send_update(make_update('1, '1, '1, '1, 0, 32'h0000_0000), 0);
      send_update(make_update('1, '1, '1, '1, 0, 32'hFF00_1000), 0);
      send_update(make_update('0, '0, '0, '0, 0, 32'h0008_0000), 0);
      send_update(make_update('0, '0, '0, '0, 0, 32'h0007_0000), 0);
      send_update(make_update('0, '0, '0, '0, 0, 32'h00FF_FFFF), 0);

      // Largest forced frame with no memory: region end clamps to zero
      s = '{1'b1, 16'hFFFF, 12'hFFF, 1'b1, '0};
      apply_setup(s);
      send_update(make_update('0, '0, '0, '0, 0, 32'h0012_3456), 0);
      send_update(make_update('0, '0, '0, '0, 0, 32'hAB00_0000), 0);
   endtask

   initial begin : stimulus
      tracker_setup_type s;
      int gap_pct;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      for (int p = 0; p < N_PHASES; p++) begin
         s.forced_width  = vfst_pkg::WIDTH_W'($urandom());
         s.forced_height = vfst_pkg::HEIGHT_W'($urandom());
         s.memory_size   = vfst_pkg::DEF_MEMSZ;
         s.force_size    = 1'b0;
         s.track_regions = 1'b1;
         case (p)
            0: gap_pct = 0;
            1: begin
               gap_pct = 59;
               s.memory_size = vfst_pkg::MEMSZ_W'($urandom_range(0, 16777216));
            end
            2: begin
               gap_pct = 0;
               s.force_size    = 1'b1;
               s.forced_width  = vfst_pkg::WIDTH_W'($urandom_range(1, 1000));
               s.forced_height = vfst_pkg::HEIGHT_W'($urandom_range(1, 600));
               s.memory_size   = vfst_pkg::MEMSZ_W'(16777216);
            end
            default: begin
               gap_pct = 27;
               s.track_regions = 1'b0;
            end
         endcase
         apply_setup(s);
         for (int n = 0; n < RANDOM_ITEMS; n++) send_update(random_update(), gap_pct);
      end

      start <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d updates, %0d results checked; %0d end recomputes, %0d forced",
               sb.n_updates, sb.n_checked, sb.n_recomputed, sb.n_forced);
      $display("regions: %0d inserted, %0d overlaps, %0d slot-zero overwrites",
               sb.n_inserted, sb.n_overlaps, sb.n_overwrites);
      if (sb.n_errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
